FILE: hw/rtl/twac_pkg.sv
// ----------------------------------------------------------------------------
// twac_pkg - shared types and constants for the three-way alignment cost block
// Column kind codes, register indexes, front-to-back queue entry and helpers.
// ----------------------------------------------------------------------------
package twac_pkg;

    // Column kind codes as they arrive on the input stream
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_MATCH = 2'd0;
    localparam kind_t KIND_DEL   = 2'd1;
    localparam kind_t KIND_INS   = 2'd2;
    localparam kind_t KIND_RSVD  = 2'd3;   // unused code, column is rejected

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_MISMATCH   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_OPEN   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INS_EXTEND = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEL_EXTEND = 8'd3;

    localparam int unsigned COST_W = 32;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned PEN_W  = 8;
    localparam int unsigned COL_W  = 12;   // worst column cost < 4096

    typedef struct packed {
        logic [PEN_W-1:0] mismatch_cost;
        logic [PEN_W-1:0] gap_open_cost;
        logic [PEN_W-1:0] insert_extend_cost;
        logic [PEN_W-1:0] delete_extend_cost;
    } cfg_t;

    // One classified column, front to back
    typedef struct packed {
        kind_t       kind_a;
        kind_t       kind_b;
        kind_t       kind_c;
        logic        has_ins;
        logic [1:0]  del_cnt;
        logic [1:0]  mis_cnt;
        logic        bad;
        logic        last;
    } entry_t;

    // Small count (0..3) times an 8-bit cost, shift and add
    function automatic logic [PEN_W+1:0] cost_times(input logic [1:0] n,
                                                    input logic [PEN_W-1:0] c);
        logic [PEN_W+1:0] p0;
        logic [PEN_W+1:0] p1;
        begin
            p0 = {2'b00, c} & {(PEN_W+2){n[0]}};
            p1 = {1'b0, c, 1'b0} & {(PEN_W+2){n[1]}};
            cost_times = p0 + p1;
        end
    endfunction

endpackage

FILE: hw/rtl/three_way_alignment_cost.sv
// ----------------------------------------------------------------------------
// three_way_alignment_cost - affine-gap cost accumulator for 3-row alignments
// Streams alignment columns in and the running alignment cost out.
// ----------------------------------------------------------------------------
// One column item per clock, sustained while the cost stream is not stalled.
// A column is classified (legality, deletion/insertion counts, character
// mismatch count) on the way into a two-entry queue; the accumulator drains
// the queue, charges gap-open against the previous column's kinds, adds
// insert- or delete-extend and mismatch costs, and adds the column cost to a
// 32-bit total that sticks at all ones. A column reaches the output through
// the queue register and then the result register; the accumulator's
// add-and-saturate loop around the total register sets the one-per-cycle
// rate. Each column gives exactly one output item: tlast marks the column
// that closed the alignment (total and kinds then restart), tuser marks a
// rejected column (no match row, two or more insertions, or kind code 3),
// which reports the unchanged total and is otherwise ignored. Cost registers
// are written through the cfg port (always ready); the user must write them
// only while the block idles, which the block itself does not enforce;
// indexes above three are dropped.
// ----------------------------------------------------------------------------
module three_way_alignment_cost (
    input  logic                              aclk,
    input  logic                              aresetn,
    // column stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // kind_a[1:0], kind_b[3:2], kind_c[5:4], char_a[13:6], char_b[21:14],
    // char_c[29:22], zero fill [31:30]
    input  logic [31:0]                       s_axis_tdata,
    input  logic                              s_axis_tlast,   // last_column
    // cost stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,   // running_cost[31:0]
    output logic                              m_axis_tlast,   // alignment_done
    output logic                              m_axis_tuser,   // bad_column
    // cost register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [twac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_data
);

    twac_pkg::cfg_t   cfg_reg, cfg_next;
    twac_pkg::entry_t front_entry;
    twac_pkg::entry_t queue_entry;
    logic             queue_valid;
    logic             back_ready;

    // ---- cost registers --------------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                twac_pkg::REG_MISMATCH:   cfg_next.mismatch_cost      = cfg_data;
                twac_pkg::REG_GAP_OPEN:   cfg_next.gap_open_cost      = cfg_data;
                twac_pkg::REG_INS_EXTEND: cfg_next.insert_extend_cost = cfg_data;
                twac_pkg::REG_DEL_EXTEND: cfg_next.delete_extend_cost = cfg_data;
                default: ;   // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mismatch_cost      <= 8'd1;
            cfg_reg.gap_open_cost      <= 8'd3;
            cfg_reg.insert_extend_cost <= 8'd1;
            cfg_reg.delete_extend_cost <= 8'd1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---- front: classify column -------------------------------------------
    twac_front u_front (
        .kind_a      (s_axis_tdata[1:0]),
        .kind_b      (s_axis_tdata[3:2]),
        .kind_c      (s_axis_tdata[5:4]),
        .char_a      (s_axis_tdata[13:6]),
        .char_b      (s_axis_tdata[21:14]),
        .char_c      (s_axis_tdata[29:22]),
        .last_column (s_axis_tlast),
        .entry       (front_entry)
    );

    // ---- queue: decouples input and output stalls -------------------------
    twac_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_entry  (front_entry),
        .out_valid (queue_valid),
        .out_ready (back_ready),
        .out_entry (queue_entry)
    );

    // ---- back: accumulate and hold the result -----------------------------
    twac_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (queue_valid),
        .in_ready  (back_ready),
        .in_entry  (queue_entry),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_cost  (m_axis_tdata),
        .out_done  (m_axis_tlast),
        .out_bad   (m_axis_tuser)
    );

endmodule

FILE: hw/rtl/twac_front.sv
// ----------------------------------------------------------------------------
// twac_front - column classifier
// Checks a column for legality and boils it down to counts for the back end.
// ----------------------------------------------------------------------------
module twac_front (
    input  twac_pkg::kind_t                 kind_a,
    input  twac_pkg::kind_t                 kind_b,
    input  twac_pkg::kind_t                 kind_c,
    input  logic [twac_pkg::CHAR_W-1:0]     char_a,
    input  logic [twac_pkg::CHAR_W-1:0]     char_b,
    input  logic [twac_pkg::CHAR_W-1:0]     char_c,
    input  logic                            last_column,
    output twac_pkg::entry_t                entry
);

    logic       ma, mb, mc;
    logic       ia, ib, ic;
    logic       da, db, dc;
    logic       any_rsvd;
    logic [1:0] n_match;
    logic [1:0] n_ins;
    logic       ne_ab, ne_bc, ne_ac;
    logic [1:0] mis_cnt;

    always_comb begin
        ma = (kind_a == twac_pkg::KIND_MATCH);
        mb = (kind_b == twac_pkg::KIND_MATCH);
        mc = (kind_c == twac_pkg::KIND_MATCH);
        ia = (kind_a == twac_pkg::KIND_INS);
        ib = (kind_b == twac_pkg::KIND_INS);
        ic = (kind_c == twac_pkg::KIND_INS);
        da = (kind_a == twac_pkg::KIND_DEL);
        db = (kind_b == twac_pkg::KIND_DEL);
        dc = (kind_c == twac_pkg::KIND_DEL);
        any_rsvd = (kind_a == twac_pkg::KIND_RSVD) || (kind_b == twac_pkg::KIND_RSVD) ||
                   (kind_c == twac_pkg::KIND_RSVD);
        n_match = {1'b0, ma} + {1'b0, mb} + {1'b0, mc};
        n_ins   = {1'b0, ia} + {1'b0, ib} + {1'b0, ic};

        ne_ab = (char_a != char_b);
        ne_bc = (char_b != char_c);
        ne_ac = (char_a != char_c);

        // x-y-x over three rows counts once, not twice
        if (ma && mb && mc) begin
            mis_cnt = {1'b0, ne_ab} + {1'b0, ne_bc};
            if (!ne_ac && ne_ab) begin
                mis_cnt = 2'd1;
            end
        end else if (ma && mb) begin
            mis_cnt = {1'b0, ne_ab};
        end else if (ma && mc) begin
            mis_cnt = {1'b0, ne_ac};
        end else if (mb && mc) begin
            mis_cnt = {1'b0, ne_bc};
        end else begin
            mis_cnt = 2'd0;
        end

        entry.kind_a  = kind_a;
        entry.kind_b  = kind_b;
        entry.kind_c  = kind_c;
        entry.has_ins = (n_ins != 2'd0);
        entry.del_cnt = {1'b0, da} + {1'b0, db} + {1'b0, dc};
        entry.mis_cnt = mis_cnt;
        entry.bad     = any_rsvd || (n_match == 2'd0) || (n_ins > 2'd1);
        entry.last    = last_column;
    end

endmodule

FILE: hw/rtl/twac_queue.sv
// ----------------------------------------------------------------------------
// twac_queue - two-entry queue between classifier and accumulator
// Head/tail register pair; full throughput with simultaneous push and pop.
// ----------------------------------------------------------------------------
module twac_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  twac_pkg::entry_t  in_entry,
    output logic              out_valid,
    input  logic              out_ready,
    output twac_pkg::entry_t  out_entry
);

    logic [1:0]       count_reg, count_next;
    twac_pkg::entry_t head_reg, head_next;
    twac_pkg::entry_t tail_reg, tail_next;
    logic             push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_entry = head_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (push && !pop) begin
            if (count_reg == 2'd0) begin
                head_next = in_entry;
            end else begin
                tail_next = in_entry;
            end
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end else if (pop && push) begin
            if (count_reg == 2'd1) begin
                head_next = in_entry;
            end else begin
                head_next = tail_reg;
                tail_next = in_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

FILE: hw/rtl/twac_back.sv
// ----------------------------------------------------------------------------
// twac_back - column cost and running total
// Applies gap-open against the previous kinds, adds with saturation and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module twac_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  twac_pkg::cfg_t                  cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  twac_pkg::entry_t                in_entry,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [twac_pkg::COST_W-1:0]     out_cost,
    output logic                            out_done,
    output logic                            out_bad
);

    logic [twac_pkg::COST_W-1:0] total_reg, total_next;
    twac_pkg::kind_t             prev_a_reg, prev_a_next;
    twac_pkg::kind_t             prev_b_reg, prev_b_next;
    twac_pkg::kind_t             prev_c_reg, prev_c_next;
    logic                        valid_reg, valid_next;
    logic [twac_pkg::COST_W-1:0] cost_reg, cost_next;
    logic                        done_reg, done_next;
    logic                        bad_reg, bad_next;

    logic                        take;
    logic                        ga, gb, gc;
    logic [1:0]                  gap_cnt;
    logic [twac_pkg::COL_W-1:0]  body;
    logic [twac_pkg::COL_W-1:0]  col;
    logic [twac_pkg::COST_W:0]   sum;
    logic [twac_pkg::COST_W-1:0] sat;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_cost  = cost_reg;
    assign out_done  = done_reg;
    assign out_bad   = bad_reg;

    always_comb begin
        ga = (in_entry.kind_a != twac_pkg::KIND_MATCH) && (in_entry.kind_a != prev_a_reg);
        gb = (in_entry.kind_b != twac_pkg::KIND_MATCH) && (in_entry.kind_b != prev_b_reg);
        gc = (in_entry.kind_c != twac_pkg::KIND_MATCH) && (in_entry.kind_c != prev_c_reg);
        gap_cnt = {1'b0, ga} + {1'b0, gb} + {1'b0, gc};

        if (in_entry.has_ins) begin
            body = {{(twac_pkg::COL_W-twac_pkg::PEN_W){1'b0}}, cfg.insert_extend_cost};
        end else begin
            body = {2'b00, twac_pkg::cost_times(in_entry.del_cnt, cfg.delete_extend_cost)}
                 + {2'b00, twac_pkg::cost_times(in_entry.mis_cnt, cfg.mismatch_cost)};
        end
        col = body + {2'b00, twac_pkg::cost_times(gap_cnt, cfg.gap_open_cost)};

        sum = {1'b0, total_reg}
            + {{(twac_pkg::COST_W+1-twac_pkg::COL_W){1'b0}}, col};
        sat = sum[twac_pkg::COST_W] ? {twac_pkg::COST_W{1'b1}} : sum[twac_pkg::COST_W-1:0];
    end

    always_comb begin
        total_next  = total_reg;
        prev_a_next = prev_a_reg;
        prev_b_next = prev_b_reg;
        prev_c_next = prev_c_reg;
        valid_next  = valid_reg && !out_ready;
        cost_next   = cost_reg;
        done_next   = done_reg;
        bad_next    = bad_reg;
        if (take) begin
            valid_next = 1'b1;
            if (in_entry.bad) begin
                // rejected column: report, leave state alone
                cost_next = total_reg;
                done_next = 1'b0;
                bad_next  = 1'b1;
            end else begin
                cost_next = sat;
                done_next = in_entry.last;
                bad_next  = 1'b0;
                if (in_entry.last) begin
                    total_next  = '0;
                    prev_a_next = twac_pkg::KIND_MATCH;
                    prev_b_next = twac_pkg::KIND_MATCH;
                    prev_c_next = twac_pkg::KIND_MATCH;
                end else begin
                    total_next  = sat;
                    prev_a_next = in_entry.kind_a;
                    prev_b_next = in_entry.kind_b;
                    prev_c_next = in_entry.kind_c;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg  <= '0;
            prev_a_reg <= twac_pkg::KIND_MATCH;
            prev_b_reg <= twac_pkg::KIND_MATCH;
            prev_c_reg <= twac_pkg::KIND_MATCH;
            valid_reg  <= 1'b0;
        end else begin
            total_reg  <= total_next;
            prev_a_reg <= prev_a_next;
            prev_b_reg <= prev_b_next;
            prev_c_reg <= prev_c_next;
            valid_reg  <= valid_next;
        end
        cost_reg <= cost_next;
        done_reg <= done_next;
        bad_reg  <= bad_next;
    end

endmodule

FILE: tb/sv/tb_three_way_alignment_cost.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_way_alignment_cost - self-checking bench for the alignment scorer
// Streams directed and random alignment columns through the block under
// several cost settings, predicts each running total and compares every
// output item field by field, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_three_way_alignment_cost;

    localparam twac_pkg::kind_t KIND_BAD = twac_pkg::KIND_RSVD;  // always rejected
    localparam int    NUM_PHASES = 7;
    localparam int    PHASE_COLS = 215;    // minimum random columns per cost setting
    localparam int    STALL_LIMIT = 2000;  // cycles without any handshake
    localparam int    IDX_W = twac_pkg::CFG_IDX_W;

    typedef struct packed {
        logic            last_column;
        logic [7:0]      char_c;
        logic [7:0]      char_b;
        logic [7:0]      char_a;
        twac_pkg::kind_t kind_c;
        twac_pkg::kind_t kind_b;
        twac_pkg::kind_t kind_a;
    } column_t;

    typedef struct {
        logic [31:0] running_cost;
        logic        alignment_done;
        logic        bad_column;
    } column_score_t;

    // ------------------------------------------------------------------------
    // DUT ports; every input is known from time zero
    // ------------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    three_way_alignment_cost dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Scoring state mirrored by the bench
    // ------------------------------------------------------------------------
    twac_pkg::cfg_t costs = '{mismatch_cost: 8'd1, gap_open_cost: 8'd3,
                              insert_extend_cost: 8'd1, delete_extend_cost: 8'd1};
    logic [31:0] acc_total = '0;
    twac_pkg::kind_t prev_kinds [3] = '{twac_pkg::KIND_MATCH, twac_pkg::KIND_MATCH,
                                        twac_pkg::KIND_MATCH};

    column_t       pending_columns [$];
    column_score_t expected_scores [$];

    bit allow_idle = 1'b1;
    int n_errors = 0;
    int n_results = 0;
    int n_closed = 0;
    int n_rejected = 0;
    int n_settings = 1;

    // Running-total predictor: one column in, one score out, state updated.
    function automatic column_score_t score_column(input column_t col);
        twac_pkg::kind_t kinds [3];
        logic [7:0]      chars [3];
        logic [7:0]      matched [3];
        int              n_match;
        int              n_del;
        int              n_ins;
        int              n_used;
        logic [63:0]     col_cost;
        logic [63:0]     sum;
        column_score_t   score;
        kinds = '{col.kind_a, col.kind_b, col.kind_c};
        chars = '{col.char_a, col.char_b, col.char_c};
        n_match = 0;
        n_del = 0;
        n_ins = 0;
        foreach (kinds[r]) begin
            if (kinds[r] == twac_pkg::KIND_MATCH) n_match++;
            if (kinds[r] == twac_pkg::KIND_DEL)   n_del++;
            if (kinds[r] == twac_pkg::KIND_INS)   n_ins++;
        end
        // rejected column: report the total, leave state alone
        if (n_match + n_del + n_ins != 3 || n_match == 0 || n_ins > 1) begin
            score = '{acc_total, 1'b0, 1'b1};
            return score;
        end
        col_cost = '0;
        foreach (kinds[r])
            if (kinds[r] != twac_pkg::KIND_MATCH && kinds[r] != prev_kinds[r])
                col_cost += costs.gap_open_cost;
        if (n_ins > 0) begin
            col_cost += costs.insert_extend_cost;
        end else begin
            col_cost += costs.delete_extend_cost * n_del;
            n_used = 0;
            foreach (kinds[r])
                if (kinds[r] == twac_pkg::KIND_MATCH) begin
                    matched[n_used] = chars[r];
                    n_used++;
                end
            for (int i = 1; i < n_used; i++)
                if (matched[i-1] != matched[i]) col_cost += costs.mismatch_cost;
            // x-y-x across three match rows is charged once, not twice
            if (n_used == 3 && matched[0] == matched[2] && matched[0] != matched[1])
                col_cost -= costs.mismatch_cost;
        end
        sum = acc_total + col_cost;
        acc_total = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        prev_kinds = kinds;
        score = '{acc_total, col.last_column, 1'b0};
        if (col.last_column) begin
            acc_total = '0;
            prev_kinds = '{twac_pkg::KIND_MATCH, twac_pkg::KIND_MATCH,
                           twac_pkg::KIND_MATCH};
        end
        return score;
    endfunction

    // ------------------------------------------------------------------------
    // Column driver: pops pending items, random idle bursts between them
    // ------------------------------------------------------------------------
    int s_gap = 0;

    always @(posedge aclk) begin : drive_columns
        column_t col;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                col = {s_axis_tlast, s_axis_tdata[29:0]};
                expected_scores.push_back(score_column(col));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_columns.size() > 0) begin
                    if (allow_idle && $urandom_range(0, 9) == 0) begin
                        s_gap = $urandom_range(1, 17) - 1;
                        s_axis_tvalid <= 1'b0;
                    end else begin
                        col = pending_columns.pop_front();
                        s_axis_tdata  <= {2'b00, col.char_c, col.char_b, col.char_a,
                                          col.kind_c, col.kind_b, col.kind_a};
                        s_axis_tlast  <= col.last_column;
                        s_axis_tvalid <= 1'b1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Score monitor: random backpressure, compares against the oldest score
    // ------------------------------------------------------------------------
    int m_gap = 0;

    always @(posedge aclk) begin : check_scores
        column_score_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (expected_scores.size() == 0) begin
                    $error("score item with no column outstanding: cost %0d",
                           m_axis_tdata);
                    n_errors++;
                end else begin
                    want = expected_scores.pop_front();
                    if (want.alignment_done) n_closed++;
                    if (want.bad_column) n_rejected++;
                    if (m_axis_tdata !== want.running_cost) begin
                        $error("running_cost: expected %0d, actual %0d",
                               want.running_cost, m_axis_tdata);
                        n_errors++;
                    end
                    if (m_axis_tlast !== want.alignment_done) begin
                        $error("alignment_done: expected %0b, actual %0b",
                               want.alignment_done, m_axis_tlast);
                        n_errors++;
                    end
                    if (m_axis_tuser !== want.bad_column) begin
                        $error("bad_column: expected %0b, actual %0b",
                               want.bad_column, m_axis_tuser);
                        n_errors++;
                    end
                end
            end
            if (m_gap > 0) begin
                m_gap--;
                m_axis_tready <= 1'b0;
            end else if (allow_idle && $urandom_range(0, 7) == 0) begin
                m_gap = $urandom_range(1, 17) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any handshake resets the count
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d scores pending",
                         STALL_LIMIT, expected_scores.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic column_t make_column(input twac_pkg::kind_t ka,
                                            input twac_pkg::kind_t kb,
                                            input twac_pkg::kind_t kc,
                                            input logic [7:0] ca,
                                            input logic [7:0] cb, input logic [7:0] cc,
                                            input logic last);
        column_t col;
        col = '{last_column: last, char_c: cc, char_b: cb, char_a: ca,
                kind_c: kc, kind_b: kb, kind_a: ka};
        return col;
    endfunction

    // Small alphabet most of the time so equal pairs and x-y-x show up often.
    function automatic logic [7:0] random_char();
        logic [7:0] alphabet [4];
        alphabet = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return alphabet[$urandom_range(0, 3)];
    endfunction

    function automatic column_t random_column(input bit noisy);
        twac_pkg::kind_t kinds [3];
        int              v;
        int              n_match;
        int              n_ins;
        if (noisy) begin
            foreach (kinds[r]) kinds[r] = twac_pkg::kind_t'($urandom_range(0, 3));
        end else begin
            // legal column: at least one match row, at most one insertion
            do begin
                n_match = 0;
                n_ins = 0;
                foreach (kinds[r]) begin
                    v = $urandom_range(0, 9);
                    kinds[r] = (v < 5) ? twac_pkg::KIND_MATCH :
                               (v < 8) ? twac_pkg::KIND_DEL : twac_pkg::KIND_INS;
                    if (kinds[r] == twac_pkg::KIND_MATCH) n_match++;
                    if (kinds[r] == twac_pkg::KIND_INS) n_ins++;
                end
            end while (n_match == 0 || n_ins > 1);
        end
        return make_column(kinds[0], kinds[1], kinds[2], random_char(),
                           random_char(), random_char(), 1'b0);
    endfunction

    // One alignment of random length; a few broken columns mixed in.
    task automatic queue_alignment(output int n_cols);
        column_t col;
        bit      noisy;
        n_cols = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 60)
                                                : $urandom_range(1, 12);
        for (int i = 0; i < n_cols; i++) begin
            noisy = ($urandom_range(0, 9) == 0);
            col = random_column(noisy);
            col.last_column = (i == n_cols - 1) || (noisy && $urandom_range(0, 1));
            pending_columns.push_back(col);
        end
    endtask

    task automatic queue_random_columns(input int target);
        int queued;
        int n_cols;
        queued = 0;
        while (queued < target) begin
            queue_alignment(n_cols);
            queued += n_cols;
        end
    endtask

    // Returns once every queued column is scored, plus a little settling time.
    // Sampled on the falling edge so the driver's updates have settled.
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_columns.size() != 0 || s_axis_tvalid || expected_scores.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            twac_pkg::REG_MISMATCH:   costs.mismatch_cost = val;
            twac_pkg::REG_GAP_OPEN:   costs.gap_open_cost = val;
            twac_pkg::REG_INS_EXTEND: costs.insert_extend_cost = val;
            twac_pkg::REG_DEL_EXTEND: costs.delete_extend_cost = val;
            default: ;      // out-of-range index is dropped
        endcase
    endtask

    task automatic set_costs(input logic [7:0] mis, input logic [7:0] gap,
                             input logic [7:0] ins, input logic [7:0] del);
        cfg_write(IDX_W'($urandom_range(4, 255)), 8'($urandom_range(0, 255)));
        cfg_write(twac_pkg::REG_MISMATCH, mis);
        cfg_write(twac_pkg::REG_GAP_OPEN, gap);
        cfg_write(twac_pkg::REG_INS_EXTEND, ins);
        cfg_write(twac_pkg::REG_DEL_EXTEND, del);
        cfg_write(IDX_W'(8'hFF), 8'hFF);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed columns under the reset costs
        pending_columns.push_back(make_column(
            twac_pkg::KIND_MATCH, twac_pkg::KIND_MATCH, twac_pkg::KIND_MATCH,
            8'h00, 8'h00, 8'h00, 1'b0));
        // x-y-x: two differing pairs, one taken back
        pending_columns.push_back(make_column(
            twac_pkg::KIND_MATCH, twac_pkg::KIND_MATCH, twac_pkg::KIND_MATCH,
            8'hFF, 8'h00, 8'hFF, 1'b0));
        pending_columns.push_back(make_column(
            twac_pkg::KIND_MATCH, twac_pkg::KIND_MATCH, twac_pkg::KIND_MATCH,
            8'h01, 8'h02, 8'h03, 1'b0));
        // deletion opens, then extends
        pending_columns.push_back(make_column(
            twac_pkg::KIND_MATCH, twac_pkg::KIND_MATCH, twac_pkg::KIND_DEL,
            8'h41, 8'h42, 8'h00, 1'b0));
        pending_columns.push_back(make_column(
            twac_pkg::KIND_MATCH, twac_pkg::KIND_MATCH, twac_pkg::KIND_DEL,
            8'h41, 8'h41, 8'h7F, 1'b0));
        // insertion opens, then extends
        pending_columns.push_back(make_column(
            twac_pkg::KIND_MATCH, twac_pkg::KIND_INS, twac_pkg::KIND_MATCH,
            8'h10, 8'h20, 8'h30, 1'b0));
        pending_columns.push_back(make_column(
            twac_pkg::KIND_MATCH, twac_pkg::KIND_INS, twac_pkg::KIND_MATCH,
            8'h10, 8'h20, 8'h30, 1'b0));
        // rejected: two insertions, no match row, illegal kind with last set
        pending_columns.push_back(make_column(
            twac_pkg::KIND_INS, twac_pkg::KIND_INS, twac_pkg::KIND_MATCH,
            8'hFF, 8'hFF, 8'hFF, 1'b0));
        pending_columns.push_back(make_column(
            twac_pkg::KIND_DEL, twac_pkg::KIND_DEL, twac_pkg::KIND_DEL,
            8'h00, 8'h00, 8'h00, 1'b0));
        pending_columns.push_back(make_column(
            KIND_BAD, twac_pkg::KIND_MATCH, twac_pkg::KIND_MATCH,
            8'hFF, 8'h00, 8'hFF, 1'b1));
        pending_columns.push_back(make_column(
            twac_pkg::KIND_DEL, twac_pkg::KIND_DEL, twac_pkg::KIND_MATCH,
            8'hFF, 8'hFF, 8'hFF, 1'b0));
        pending_columns.push_back(make_column(
            twac_pkg::KIND_MATCH, twac_pkg::KIND_INS, twac_pkg::KIND_DEL,
            8'h00, 8'hFF, 8'h00, 1'b0));
        pending_columns.push_back(make_column(
            twac_pkg::KIND_MATCH, twac_pkg::KIND_MATCH, twac_pkg::KIND_MATCH,
            8'hAA, 8'h55, 8'hAA, 1'b1));
        // fresh alignment: previous kinds are back to all match
        pending_columns.push_back(make_column(
            twac_pkg::KIND_DEL, twac_pkg::KIND_MATCH, twac_pkg::KIND_MATCH,
            8'h00, 8'h80, 8'h80, 1'b0));
        pending_columns.push_back(make_column(
            twac_pkg::KIND_INS, twac_pkg::KIND_DEL, twac_pkg::KIND_MATCH,
            8'h01, 8'h02, 8'h03, 1'b1));
        pending_columns.push_back(make_column(
            twac_pkg::KIND_MATCH, twac_pkg::KIND_MATCH, twac_pkg::KIND_MATCH,
            8'hFF, 8'hFF, 8'h00, 1'b1));
        pending_columns.push_back(make_column(
            twac_pkg::KIND_MATCH, twac_pkg::KIND_DEL, twac_pkg::KIND_MATCH,
            8'h12, 8'h34, 8'h56, 1'b0));
        pending_columns.push_back(make_column(
            twac_pkg::KIND_MATCH, twac_pkg::KIND_MATCH, KIND_BAD,
            8'h00, 8'h00, 8'h00, 1'b0));
        pending_columns.push_back(make_column(
            twac_pkg::KIND_DEL, twac_pkg::KIND_MATCH, twac_pkg::KIND_INS,
            8'hC3, 8'h3C, 8'hC3, 1'b1));
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: set_costs(8'd255, 8'd255, 8'd255, 8'd255);
                1: set_costs(8'd1, 8'd0, 8'd1, 8'd1);
                default: set_costs(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
            endcase
            // one quiet phase mid-run, and none at the end
            allow_idle = (ph != 3) && (ph != NUM_PHASES - 1);
            queue_random_columns(PHASE_COLS / 2);
            // sender holds off until every score is back
            wait_drained();
            queue_random_columns(PHASE_COLS - PHASE_COLS / 2);
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        $display("Scored %0d columns: %0d alignments closed, %0d columns rejected,",
                 n_results, n_closed, n_rejected);
        $display("over %0d cost settings including all-max and all-min costs.",
                 n_settings);
        if (n_errors == 0 && expected_scores.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/twac_pkg.sv
hw/rtl/twac_front.sv
hw/rtl/twac_queue.sv
hw/rtl/twac_back.sv
hw/rtl/three_way_alignment_cost.sv
tb/sv/tb_three_way_alignment_cost.sv
